### rtl/i2c_master_transfer_sequencer_macros.svh
// Assertion macros for the I2C transfer sequencer.
// Expects clk and arst_n in the scope of use.
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_MACROS_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_MACROS_SVH

// check that cons holds whenever ante holds
`define I2CSEQ_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("i2c sequencer check failed");

// check that expr holds at every edge out of reset
`define I2CSEQ_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("i2c sequencer check failed");

`endif

### rtl/i2cseq_pkg.sv
// Types and constants for the I2C transfer sequencer.
// No dependencies.
package i2cseq_pkg;

	localparam int DEF_BUF_DEPTH = 16;
	localparam logic [15:0] TIMEOUT_RST = 16'd1000;

	localparam logic [1:0] FN_BEGIN = 2'd0;
	localparam logic [1:0] FN_EVENT = 2'd1;
	localparam logic [1:0] FN_TICK  = 2'd2;
	localparam logic [1:0] FN_LOAD  = 2'd3;

	localparam logic [7:0] ST_START    = 8'h08;
	localparam logic [7:0] ST_RESTART  = 8'h10;
	localparam logic [7:0] ST_ADDR_W   = 8'h18;
	localparam logic [7:0] ST_DATA_W   = 8'h28;
	localparam logic [7:0] ST_ADDR_R   = 8'h40;
	localparam logic [7:0] ST_DATA_ACK = 8'h50;
	localparam logic [7:0] ST_DATA_NAK = 8'h58;

	localparam logic [1:0] ACK_KEEP = 2'd0;
	localparam logic [1:0] ACK_SET  = 2'd1;
	localparam logic [1:0] ACK_CLR  = 2'd2;

	localparam logic [3:0] ERR_OK       = 4'd0;
	localparam logic [3:0] ERR_TIMEOUT  = 4'd1;
	localparam logic [3:0] ERR_START    = 4'd2;
	localparam logic [3:0] ERR_ADDR_W   = 4'd3;
	localparam logic [3:0] ERR_DATA_W   = 4'd4;
	localparam logic [3:0] ERR_RESTART  = 4'd5;
	localparam logic [3:0] ERR_ADDR_R   = 4'd6;
	localparam logic [3:0] ERR_READ     = 4'd7;
	localparam logic [3:0] ERR_LAST     = 4'd8;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_START,
		PH_ADDR_W,
		PH_DATA_W,
		PH_RESTART,
		PH_ADDR_R,
		PH_READ,
		PH_LAST
	} phase_t;

	typedef struct packed {
		logic [1:0] func;
		logic [6:0] slave_addr;
		logic [4:0] write_count;
		logic [4:0] read_count;
		logic [7:0] status_code;
		logic [7:0] rx_byte;
		logic [7:0] tx_byte;
	} in_item_t;

	typedef struct packed {
		logic       start_request;
		logic       clear_start;
		logic       stop_request;
		logic [1:0] ack_mode;
		logic       clear_flag;
		logic       data_valid;
		logic [7:0] data_out;
		logic       read_valid;
		logic [7:0] read_data;
		logic       done_res;
		logic [3:0] error_code;
	} out_item_t;

endpackage

### rtl/i2c_master_transfer_sequencer.sv
// I2C master write-then-read frame sequencer, top level.
// Depends on i2cseq_pkg and i2c_master_transfer_sequencer_macros.svh.
//
// Usage:
// in channel (in_valid/in_ready/in_data) carries frame begin, engine
// completion events, timeout ticks and transmit buffer loads. Every accepted
// item yields exactly one item on the out channel (out_valid/out_ready/
// out_data) with the engine requests for that step.
// Results are registered. One item per cycle is sustained while out_ready
// holds; the step is a single pass of compare and select logic between
// the input handshake and the output register.
// A one-entry skid register behind the output register lets an item be
// accepted while the previous result is stalled; in_ready drops only when
// both hold results.
// The cfg channel (cfg_valid/cfg_ready/cfg_data) writes the timeout in
// ticks and is always ready; the user must write it only while no frame is
// running; the block does not enforce this. Reset idles the sequencer,
// empties the output stages, sets timeout to 1000 ticks, keeps the buffer.
`include "i2c_master_transfer_sequencer_macros.svh"

module i2c_master_transfer_sequencer #(
	parameter int BUF_DEPTH = i2cseq_pkg::DEF_BUF_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  i2cseq_pkg::in_item_t  in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output i2cseq_pkg::out_item_t out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [15:0]           cfg_data
);
	import i2cseq_pkg::*;

	localparam int IDX_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam int CNT_W = $clog2(BUF_DEPTH + 1);
	localparam logic [4:0] WL_MAX = 5'((BUF_DEPTH > 31) ? 31 : BUF_DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(BUF_DEPTH);

	phase_t           phase_q, phase_d;
	logic [6:0]       addr_q, addr_d;
	logic [4:0]       wl_q, wl_d;
	logic [4:0]       rl_q, rl_d;
	logic [CNT_W-1:0] bi_q, bi_d, bi_nxt;
	logic [CNT_W-1:0] li_q, li_d;
	logic [15:0]      wait_q, wait_d, wait_inc;
	logic [15:0]      timeout_q;
	logic             buf_we;
	logic [7:0]       buf_mem [BUF_DEPTH];
	logic [7:0]       buf_rd_q;

	out_item_t res;
	out_item_t out_q, skid_q;
	logic      out_valid_q, skid_valid_q;
	logic      in_fire, out_fire;
	logic      fin;
	logic [3:0] fin_err;

	assign in_fire   = in_valid & in_ready;
	assign out_fire  = out_valid_q & out_ready;
	assign in_ready  = ~skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign cfg_ready = 1'b1;

	assign wait_inc = (wait_q == 16'hFFFF) ? wait_q : wait_q + 16'd1;

	always_comb begin
		phase_d = phase_q;
		addr_d  = addr_q;
		wl_d    = wl_q;
		rl_d    = rl_q;
		bi_d    = bi_q;
		li_d    = li_q;
		wait_d  = wait_q;
		buf_we  = 1'b0;
		fin     = 1'b0;
		fin_err = ERR_OK;
		res     = '0;
		case (in_data.func)
			FN_BEGIN: begin
				if (phase_q == PH_IDLE) begin
					addr_d = in_data.slave_addr;
					wl_d = (32'(in_data.write_count) > BUF_DEPTH) ? WL_MAX
						: in_data.write_count;
					rl_d = in_data.read_count;
					bi_d = '0;
					wait_d = '0;
					res.clear_flag = 1'b1;
					res.start_request = 1'b1;
					phase_d = PH_START;
				end
			end
			FN_EVENT: begin
				if (phase_q != PH_IDLE) begin
					wait_d = '0;
					case (phase_q)
						PH_START: begin
							if (in_data.status_code != ST_START &&
								in_data.status_code != ST_RESTART) begin
								fin = 1'b1;
								fin_err = ERR_START;
							end else if (wl_q != '0 || rl_q != '0) begin
								res.data_valid = 1'b1;
								res.data_out = {addr_q, (wl_q == '0)};
								res.ack_mode = ACK_SET;
								res.clear_start = 1'b1;
								res.clear_flag = 1'b1;
								phase_d = (wl_q != '0) ? PH_ADDR_W : PH_ADDR_R;
							end else begin
								fin = 1'b1;
							end
						end
						PH_ADDR_W, PH_DATA_W: begin
							if (phase_q == PH_ADDR_W && in_data.status_code != ST_ADDR_W) begin
								fin = 1'b1;
								fin_err = ERR_ADDR_W;
							end else if (phase_q == PH_DATA_W &&
								in_data.status_code != ST_DATA_W) begin
								fin = 1'b1;
								fin_err = ERR_DATA_W;
							end else if (wl_q != '0) begin
								res.data_valid = 1'b1;
								res.data_out = (bi_q < DEPTH_C) ? buf_rd_q : 8'h00;
								res.clear_flag = 1'b1;
								bi_d = bi_q + CNT_W'(1);
								wl_d = wl_q - 5'd1;
								phase_d = PH_DATA_W;
							end else if (rl_q != '0) begin
								res.start_request = 1'b1;
								res.clear_flag = 1'b1;
								phase_d = PH_RESTART;
							end else begin
								fin = 1'b1;
							end
						end
						PH_RESTART: begin
							if (in_data.status_code != ST_RESTART) begin
								fin = 1'b1;
								fin_err = ERR_RESTART;
							end else begin
								res.data_valid = 1'b1;
								res.data_out = {addr_q, 1'b1};
								res.ack_mode = ACK_SET;
								res.clear_start = 1'b1;
								res.clear_flag = 1'b1;
								phase_d = PH_ADDR_R;
							end
						end
						PH_ADDR_R, PH_READ: begin
							if (phase_q == PH_ADDR_R && in_data.status_code != ST_ADDR_R) begin
								fin = 1'b1;
								fin_err = ERR_ADDR_R;
							end else if (phase_q == PH_READ &&
								in_data.status_code != ST_DATA_ACK) begin
								fin = 1'b1;
								fin_err = ERR_READ;
							end else if (rl_q == '0) begin
								fin = 1'b1;
							end else begin
								if (phase_q == PH_READ) begin
									res.read_valid = 1'b1;
									res.read_data = in_data.rx_byte;
								end
								rl_d = rl_q - 5'd1;
								res.clear_flag = 1'b1;
								if (rl_q == 5'd1) begin
									res.ack_mode = ACK_CLR;
									phase_d = PH_LAST;
								end else begin
									phase_d = PH_READ;
								end
							end
						end
						PH_LAST: begin
							fin = 1'b1;
							if (in_data.status_code != ST_DATA_NAK) begin
								fin_err = ERR_LAST;
							end else begin
								res.read_valid = 1'b1;
								res.read_data = in_data.rx_byte;
							end
						end
						default: begin
						end
					endcase
				end
			end
			FN_TICK: begin
				if (phase_q != PH_IDLE) begin
					wait_d = wait_inc;
					if (wait_inc >= timeout_q) begin
						wait_d = '0;
						fin = 1'b1;
						fin_err = ERR_TIMEOUT;
					end
				end
			end
			FN_LOAD: begin
				if (phase_q == PH_IDLE && li_q < DEPTH_C) begin
					buf_we = 1'b1;
					li_d = li_q + CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
		if (fin) begin
			res.clear_start = (fin_err != ERR_OK);
			res.stop_request = 1'b1;
			res.clear_flag = 1'b1;
			res.done_res = 1'b1;
			res.error_code = fin_err;
			phase_d = PH_IDLE;
			li_d = '0;
			wl_d = '0;
			rl_d = '0;
			bi_d = '0;
		end
	end

	assign bi_nxt = in_fire ? bi_d : bi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			addr_q    <= '0;
			wl_q      <= '0;
			rl_q      <= '0;
			bi_q      <= '0;
			li_q      <= '0;
			wait_q    <= '0;
			timeout_q <= TIMEOUT_RST;
		end else begin
			if (cfg_valid && cfg_ready) begin
				timeout_q <= cfg_data;
			end
			if (in_fire) begin
				phase_q <= phase_d;
				addr_q  <= addr_d;
				wl_q    <= wl_d;
				rl_q    <= rl_d;
				bi_q    <= bi_d;
				li_q    <= li_d;
				wait_q  <= wait_d;
			end
		end
	end

	// prefetch the entry the next write step sends
	always_ff @(posedge clk) begin
		if (in_fire && buf_we) begin
			buf_mem[li_q[IDX_W-1:0]] <= in_data.tx_byte;
		end
		buf_rd_q <= buf_mem[bi_nxt[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_fire || !out_valid_q) begin
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= in_fire;
				end
			end else if (in_fire) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_fire || !out_valid_q) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (in_fire) begin
			skid_q <= res;
		end
	end

	`I2CSEQ_ASSERT_IMPL(a_skid_behind_out, skid_valid_q, out_valid_q)
	`I2CSEQ_ASSERT_IMPL(a_err_only_on_done, out_valid_q && !out_q.done_res,
		out_q.error_code == ERR_OK)
	`I2CSEQ_ASSERT_IMPL(a_idle_counts_clear, phase_q == PH_IDLE,
		wl_q == '0 && rl_q == '0 && bi_q == '0)
	`I2CSEQ_ASSERT_ALWAYS(a_index_in_range, bi_q <= DEPTH_C && li_q <= DEPTH_C)

endmodule

### test/i2c_master_transfer_sequencer_test.sv
// Testbench for the I2C master transfer sequencer: drives frame begins, engine events,
// ticks and buffer loads under random idling and checks every engine request item.
// Depends on i2cseq_pkg and the i2c_master_transfer_sequencer RTL.
module i2c_master_transfer_sequencer_test;
	import i2cseq_pkg::*;

	localparam int BUF_DEPTH = DEF_BUF_DEPTH;
	localparam int ITEM_GOAL = 1650;
	localparam int PHASES = 8;
	localparam int STALL_LIMIT = 2000;
	localparam logic [7:0] ST_NONE = 8'hFF;

	class seq_scoreboard;
		phase_t      phase = PH_IDLE;
		logic [6:0]  target_addr = '0;
		logic [4:0]  writes_left = '0;
		logic [4:0]  reads_left = '0;
		logic [4:0]  write_idx = '0;
		logic [4:0]  load_idx = '0;
		logic [7:0]  tx_buf [BUF_DEPTH];
		logic [15:0] wait_ticks = '0;
		logic [15:0] timeout = TIMEOUT_RST;
		out_item_t   req;
		out_item_t   engine_requests_q [$];
		int unsigned mismatches = 0;
		int unsigned checked = 0;
		int unsigned frames = 0;
		int unsigned failed_frames = 0;
		int unsigned timeouts = 0;

		function void end_frame(logic [3:0] err);
			if (err != ERR_OK)
				req.clear_start = 1'b1;
			req.stop_request = 1'b1;
			req.clear_flag = 1'b1;
			req.done_res = 1'b1;
			req.error_code = err;
			phase = PH_IDLE;
			load_idx = '0;
			writes_left = '0;
			reads_left = '0;
			write_idx = '0;
			frames++;
			if (err != ERR_OK)
				failed_frames++;
			if (err == ERR_TIMEOUT)
				timeouts++;
		endfunction

		function void put_address(logic rw, phase_t next_phase);
			req.data_valid = 1'b1;
			req.data_out = {target_addr, rw};
			req.ack_mode = ACK_SET;
			req.clear_start = 1'b1;
			req.clear_flag = 1'b1;
			phase = next_phase;
		endfunction

		function void put_write_byte();
			req.data_valid = 1'b1;
			req.data_out = tx_buf[write_idx[3:0]];
			req.clear_flag = 1'b1;
			write_idx = write_idx + 5'd1;
			writes_left = writes_left - 5'd1;
			phase = PH_DATA_W;
		endfunction

		function void next_read();
			reads_left = reads_left - 5'd1;
			req.clear_flag = 1'b1;
			if (reads_left == 0) begin
				req.ack_mode = ACK_CLR;
				phase = PH_LAST;
			end else
				phase = PH_READ;
		endfunction

		function void writes_finished();
			if (reads_left != 0) begin
				req.start_request = 1'b1;
				req.clear_flag = 1'b1;
				phase = PH_RESTART;
			end else
				end_frame(ERR_OK);
		endfunction

		function void engine_event(logic [7:0] st, logic [7:0] rx);
			case (phase)
				PH_START: begin
					if (st != ST_START && st != ST_RESTART)
						end_frame(ERR_START);
					else if (writes_left != 0)
						put_address(1'b0, PH_ADDR_W);
					else if (reads_left != 0)
						put_address(1'b1, PH_ADDR_R);
					else
						end_frame(ERR_OK);
				end
				PH_ADDR_W, PH_DATA_W: begin
					if (phase == PH_ADDR_W && st != ST_ADDR_W)
						end_frame(ERR_ADDR_W);
					else if (phase == PH_DATA_W && st != ST_DATA_W)
						end_frame(ERR_DATA_W);
					else if (writes_left != 0)
						put_write_byte();
					else
						writes_finished();
				end
				PH_RESTART: begin
					if (st != ST_RESTART)
						end_frame(ERR_RESTART);
					else
						put_address(1'b1, PH_ADDR_R);
				end
				PH_ADDR_R: begin
					if (st != ST_ADDR_R)
						end_frame(ERR_ADDR_R);
					else if (reads_left != 0)
						next_read();
					else
						end_frame(ERR_OK);
				end
				PH_READ: begin
					if (st != ST_DATA_ACK)
						end_frame(ERR_READ);
					else begin
						req.read_valid = 1'b1;
						req.read_data = rx;
						next_read();
					end
				end
				PH_LAST: begin
					if (st != ST_DATA_NAK)
						end_frame(ERR_LAST);
					else begin
						req.read_valid = 1'b1;
						req.read_data = rx;
						end_frame(ERR_OK);
					end
				end
				default: ;
			endcase
		endfunction

		function bit note_item(in_item_t it);
			bit acted;
			acted = 1'b1;
			req = '0;
			case (it.func)
				FN_BEGIN: begin
					if (phase == PH_IDLE) begin
						target_addr = it.slave_addr;
						writes_left = (it.write_count > BUF_DEPTH) ? 5'(BUF_DEPTH) : it.write_count;
						reads_left = it.read_count;
						write_idx = '0;
						wait_ticks = '0;
						req.clear_flag = 1'b1;
						req.start_request = 1'b1;
						phase = PH_START;
					end else
						acted = 1'b0;
				end
				FN_EVENT: begin
					if (phase != PH_IDLE) begin
						wait_ticks = '0;
						engine_event(it.status_code, it.rx_byte);
					end else
						acted = 1'b0;
				end
				FN_TICK: begin
					if (phase != PH_IDLE) begin
						if (wait_ticks != 16'hFFFF)
							wait_ticks = wait_ticks + 16'd1;
						if (wait_ticks >= timeout) begin
							wait_ticks = '0;
							end_frame(ERR_TIMEOUT);
						end
					end else
						acted = 1'b0;
				end
				FN_LOAD: begin
					if (phase == PH_IDLE && load_idx < BUF_DEPTH) begin
						tx_buf[load_idx[3:0]] = it.tx_byte;
						load_idx = load_idx + 5'd1;
					end else
						acted = 1'b0;
				end
			endcase
			engine_requests_q.push_back(req);
			return acted;
		endfunction

		function void compare(string field, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch in %s at result %0d: expected %h, got %h",
						field, checked, want, got);
			end
		endfunction

		function void check_requests(out_item_t got);
			out_item_t want;
			checked++;
			if (engine_requests_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %0d: %h", checked, got);
				return;
			end
			want = engine_requests_q.pop_front();
			compare("start_request", 8'(want.start_request), 8'(got.start_request));
			compare("clear_start", 8'(want.clear_start), 8'(got.clear_start));
			compare("stop_request", 8'(want.stop_request), 8'(got.stop_request));
			compare("ack_mode", 8'(want.ack_mode), 8'(got.ack_mode));
			compare("clear_flag", 8'(want.clear_flag), 8'(got.clear_flag));
			compare("data_valid", 8'(want.data_valid), 8'(got.data_valid));
			compare("data_out", want.data_out, got.data_out);
			compare("read_valid", 8'(want.read_valid), 8'(got.read_valid));
			compare("read_data", want.read_data, got.read_data);
			compare("done_res", 8'(want.done_res), 8'(got.done_res));
			compare("error_code", 8'(want.error_code), 8'(got.error_code));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;

	seq_scoreboard sb;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int items = 0;
	int loaded = 0;
	int quiet_cycles = 0;

	i2c_master_transfer_sequencer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_requests(out_data);
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else if (arst_n)
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("no item moved for %0d cycles", quiet_cycles);
			$display("i2c_master_transfer_sequencer_test failed");
			$finish;
		end
	end

	function automatic in_item_t rand_item(logic [1:0] fn);
		in_item_t it;
		logic [63:0] bits;
		bits = {$urandom, $urandom};
		it = bits[$bits(in_item_t)-1:0];
		it.func = fn;
		return it;
	endfunction

	function automatic logic [7:0] good_status(phase_t ph);
		case (ph)
			PH_START:   return ($urandom_range(0, 1) != 0) ? ST_START : ST_RESTART;
			PH_ADDR_W:  return ST_ADDR_W;
			PH_DATA_W:  return ST_DATA_W;
			PH_RESTART: return ST_RESTART;
			PH_ADDR_R:  return ST_ADDR_R;
			PH_READ:    return ST_DATA_ACK;
			PH_LAST:    return ST_DATA_NAK;
			default:    return ST_NONE;
		endcase
	endfunction

	task automatic send_item(in_item_t it);
		if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do
			@(posedge clk);
		while (!in_ready);
		if (sb.note_item(it))
			items++;
		if (sb.load_idx > loaded)
			loaded = int'(sb.load_idx);
	endtask

	task automatic send_begin(logic [6:0] addr, logic [4:0] wc, logic [4:0] rc);
		in_item_t it;
		it = rand_item(FN_BEGIN);
		it.slave_addr = addr;
		it.write_count = wc;
		it.read_count = rc;
		send_item(it);
	endtask

	task automatic send_event(logic [7:0] st, logic [7:0] rx);
		in_item_t it;
		it = rand_item(FN_EVENT);
		it.status_code = st;
		it.rx_byte = rx;
		send_item(it);
	endtask

	task automatic send_tick();
		send_item(rand_item(FN_TICK));
	endtask

	task automatic send_load(logic [7:0] b);
		in_item_t it;
		it = rand_item(FN_LOAD);
		it.tx_byte = b;
		send_item(it);
	endtask

	task automatic stop_sending();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.engine_requests_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_timeout(logic [15:0] ticks);
		cfg_valid <= 1'b1;
		cfg_data <= ticks;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.timeout = ticks;
	endtask

	task automatic run_frame();
		int n;
		int wc;
		int rc;
		int r;
		n = ($urandom_range(0, 99) < 15) ? $urandom_range(16, 18) : $urandom_range(0, 4);
		repeat (n)
			send_load(8'($urandom));
		if ($urandom_range(0, 99) < 8) begin
			if ($urandom_range(0, 1) != 0)
				send_tick();
			else
				send_event(8'($urandom), 8'($urandom));
		end
		if (loaded == BUF_DEPTH && $urandom_range(0, 3) == 0)
			wc = $urandom_range(0, 31);
		else
			wc = $urandom_range(0, (loaded < 4) ? loaded : 4);
		rc = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 4);
		send_begin(7'($urandom), 5'(wc), 5'(rc));
		while (sb.phase != PH_IDLE) begin
			r = $urandom_range(0, 99);
			if (r < 78)
				send_event(good_status(sb.phase), 8'($urandom));
			else if (r < 88)
				repeat ((sb.timeout <= 24) ? $urandom_range(1, sb.timeout + 1)
					: $urandom_range(1, 3))
					send_tick();
			else if (r < 94)
				send_event(8'($urandom), 8'($urandom));
			else if (r < 97)
				send_begin(7'($urandom), 5'($urandom), 5'($urandom));
			else
				send_load(8'($urandom));
		end
	endtask

	initial begin
		logic [15:0] tmo_plan [PHASES];
		int goal;
		sb = new;
		tmo_plan = '{16'd65535, 16'd0, 16'd1, 16'd1000, 16'd2, 16'd0, 16'd65535, 16'd9};
		tmo_plan[5] = 16'($urandom_range(2, 40));
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_event(ST_START, 8'h00);
		send_tick();
		send_load(8'hFF);
		send_load(8'h00);
		send_begin(7'h7F, 5'd2, 5'd2);
		send_begin(7'h00, 5'd0, 5'd0);
		send_load(8'hA5);
		send_event(ST_START, 8'h00);
		send_event(ST_ADDR_W, 8'h00);
		send_event(ST_DATA_W, 8'h00);
		send_event(ST_DATA_W, 8'h00);
		send_event(ST_RESTART, 8'h00);
		send_event(ST_ADDR_R, 8'h00);
		send_event(ST_DATA_ACK, 8'hFF);
		send_event(ST_DATA_NAK, 8'h00);
		send_begin(7'h00, 5'd0, 5'd0);
		send_event(ST_START, 8'h00);
		send_begin(7'h2A, 5'd1, 5'd0);
		send_event(ST_RESTART, 8'h00);
		send_event(ST_ADDR_W, 8'h00);
		send_event(ST_DATA_W, 8'h00);
		send_begin(7'h55, 5'd0, 5'd1);
		send_tick();
		send_event(8'h00, 8'h00);

		for (int p = 0; p < PHASES; p++) begin
			stop_sending();
			write_timeout(tmo_plan[p]);
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 64;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 64;
				end
				default: begin
					send_idle_pct = 23;
					stall_pct = 23;
				end
			endcase
			goal = ITEM_GOAL * (p + 1) / PHASES;
			while (items < goal)
				run_frame();
		end

		stop_sending();
		repeat (8) @(posedge clk);
		$display("ran %0d items in %0d frames, %0d ended in error, %0d of them by timeout",
			items, sb.frames, sb.failed_frames, sb.timeouts);
		$display("checked %0d results over four idling patterns and timeouts from 0 to 65535",
			sb.checked);
		if (sb.mismatches == 0)
			$display("i2c_master_transfer_sequencer_test passed");
		else
			$display("i2c_master_transfer_sequencer_test failed");
		$finish;
	end
endmodule
